>>> sv/rwcp_pkg.sv
// Package with the shared types, codes and constants of the RIFF/WAVE chunk parser.
`timescale 1ns / 1ps

package rwcp_pkg;

    // Width of the RIFF size and of the chunk sizes, in bits
    localparam int SIZE_WIDTH_DEF = 32;

    // Configuration register map
    localparam int          CFG_ADDR_W  = 4;
    localparam logic [3:0]  ADDR_FORMAT = 4'h0;
    localparam logic [3:0]  ADDR_RATE   = 4'h4;
    localparam logic [3:0]  ADDR_CHANS  = 4'h8;

    localparam logic [15:0] FORMAT_RST = 16'd1;
    localparam logic [31:0] RATE_RST   = 32'd44100;
    localparam logic [15:0] CHANS_RST  = 16'd1;

    // Four-character codes as they sit in a little-endian shift word
    localparam logic [31:0] ID_RIFF = 32'h4646_4952;
    localparam logic [31:0] ID_WAVE = 32'h4556_4157;
    localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
    localparam logic [31:0] ID_DATA = 32'h6174_6164;

    // Status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_RIFF = 3'd1;
    localparam logic [2:0] ST_BAD_WAVE = 3'd2;
    localparam logic [2:0] ST_FORMAT   = 3'd3;
    localparam logic [2:0] ST_RATE     = 3'd4;
    localparam logic [2:0] ST_CHANS    = 3'd5;
    localparam logic [2:0] ST_NO_DATA  = 3'd6;

    // Header byte offsets
    localparam logic [31:0] OFS_RIFF_END = 32'd3;
    localparam logic [31:0] OFS_SIZE_END = 32'd7;
    localparam logic [31:0] OFS_WAVE_END = 32'd11;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_ID     = 3'd1,
        PH_SIZE   = 3'd2,
        PH_BODY   = 3'd3,
        PH_TRAIL  = 3'd4,
        PH_STOP   = 3'd5
    } phase_t;

    // One result as it waits in the output stage
    typedef struct packed {
        logic [2:0] status;
        logic       done;
        logic       payload;
        logic [7:0] data;
    } result_t;

endpackage

>>> sv/riff_wave_chunk_parser.sv
// Top level of the RIFF/WAVE chunk parser: byte stream in, marked byte stream out.
`timescale 1ns / 1ps
// An accepted byte goes into the result register, or the skid register while one waits.
// Throughput: one byte per cycle while the skid register is empty; per-byte work is a single
// pass of count, shift and compare logic from the parse state to the two-entry output stage.
// Reset: aresetn is synchronous and active low; it empties the output stage, returns the
// parser to the RIFF header and loads the configuration registers with their defaults.

module riff_wave_chunk_parser
    import rwcp_pkg::*;
#(
    parameter int SIZE_WIDTH = SIZE_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Byte input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] file_byte
    input  logic                  s_tlast,   // last_byte
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,   // [7:0] byte_out, [10:8] status, [15:11] zero
    output logic                  m_tuser,   // is_payload
    output logic                  m_tlast,   // done_res
    // Configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int BL_W = SIZE_WIDTH + 1;

    // ------------------------------------------------------------------
    // Configuration registers. The port never stalls, so a write lands on
    // the edge of its access cycle; unknown addresses are ignored.
    // ------------------------------------------------------------------
    logic [15:0] exp_format_reg;
    logic [31:0] exp_rate_reg;
    logic [15:0] exp_chans_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_format_reg <= FORMAT_RST;
            exp_rate_reg   <= RATE_RST;
            exp_chans_reg  <= CHANS_RST;
        end else if (cfg_wr) begin
            if (paddr == ADDR_FORMAT) begin
                exp_format_reg <= pwdata[15:0];
            end
            if (paddr == ADDR_RATE) begin
                exp_rate_reg <= pwdata;
            end
            if (paddr == ADDR_CHANS) begin
                exp_chans_reg <= pwdata[15:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == ADDR_FORMAT) begin
            prdata = {16'd0, exp_format_reg};
        end else if (paddr == ADDR_RATE) begin
            prdata = exp_rate_reg;
        end else if (paddr == ADDR_CHANS) begin
            prdata = {16'd0, exp_chans_reg};
        end
    end

    // ------------------------------------------------------------------
    // Parse state
    // ------------------------------------------------------------------
    phase_t                phase_reg, phase_next;
    logic [31:0]           offset_reg, offset_next;      // saturating file offset
    logic [SIZE_WIDTH-1:0] riff_len_reg, riff_len_next;
    logic [31:0]           id_shift_reg, id_shift_next;  // id bytes, newest at the top
    logic [31:0]           len_shift_reg, len_shift_next;
    logic                  odd_reg, odd_next;            // current chunk has a pad byte
    logic [BL_W-1:0]       left_reg, left_next;          // body bytes to come; id/size count
    logic [3:0]            body_idx_reg, body_idx_next;  // body byte index, held at eight
    logic [63:0]           fmt_shift_reg, fmt_shift_next;
    logic [2:0]            err_reg, err_next;
    logic                  seen_reg, seen_next;          // a data chunk header completed

    logic                  accept;
    logic                  payload;
    logic [2:0]            status;
    logic [31:0]           len_word;
    logic [SIZE_WIDTH-1:0] len_masked;
    logic [BL_W-1:0]       padded;
    logic                  region_end;
    logic [63:0]           fmt_word;
    logic [15:0]           fmt_tag;
    logic [15:0]           fmt_chans;
    logic [31:0]           fmt_rate;

    assign accept = s_tvalid && s_tready;

    // The shifts below take the new byte in at the top, so after four bytes
    // the word reads as a little-endian value.
    assign len_word   = {s_tdata, len_shift_reg[31:8]};
    assign len_masked = len_word[SIZE_WIDTH-1:0];
    assign padded     = BL_W'(len_masked) + BL_W'(len_masked[0]);
    assign region_end = ({1'b0, offset_reg} >= (33'(riff_len_reg) + 33'd8));
    assign fmt_word   = {s_tdata, fmt_shift_reg[63:8]};
    assign fmt_tag    = fmt_word[15:0];
    assign fmt_chans  = fmt_word[31:16];
    assign fmt_rate   = fmt_word[63:32];

    always_comb begin
        phase_next     = phase_reg;
        offset_next    = offset_reg;
        riff_len_next  = riff_len_reg;
        id_shift_next  = id_shift_reg;
        len_shift_next = len_shift_reg;
        odd_next       = odd_reg;
        left_next      = left_reg;
        body_idx_next  = body_idx_reg;
        fmt_shift_next = fmt_shift_reg;
        err_next       = err_reg;
        seen_next      = seen_reg;
        payload        = 1'b0;

        unique case (phase_reg)
            PH_HEADER: begin
                // "RIFF", four size bytes, then "WAVE"
                id_shift_next = {s_tdata, id_shift_reg[31:8]};
                if (offset_reg == OFS_RIFF_END && id_shift_next != ID_RIFF) begin
                    err_next   = ST_BAD_RIFF;
                    phase_next = PH_STOP;
                end else if (offset_reg == OFS_SIZE_END) begin
                    riff_len_next = id_shift_next[SIZE_WIDTH-1:0];
                end else if (offset_reg == OFS_WAVE_END) begin
                    if (id_shift_next != ID_WAVE) begin
                        err_next   = ST_BAD_WAVE;
                        phase_next = PH_STOP;
                    end else begin
                        phase_next = PH_ID;
                        left_next  = '0;
                    end
                end
            end
            PH_ID: begin
                // A chunk may only start inside the RIFF region.
                if (left_reg == '0 && region_end) begin
                    phase_next = PH_TRAIL;
                end else begin
                    id_shift_next = {s_tdata, id_shift_reg[31:8]};
                    left_next     = left_reg + BL_W'(1);
                    if (left_next >= BL_W'(4)) begin
                        phase_next = PH_SIZE;
                        left_next  = '0;
                    end
                end
            end
            PH_SIZE: begin
                len_shift_next = len_word;
                left_next      = left_reg + BL_W'(1);
                if (left_next >= BL_W'(4)) begin
                    len_shift_next = 32'(len_masked);
                    odd_next       = len_masked[0];
                    fmt_shift_next = '0;
                    body_idx_next  = '0;
                    if (id_shift_reg == ID_DATA) begin
                        seen_next = 1'b1;
                    end
                    if (id_shift_reg == ID_FMT && len_masked < SIZE_WIDTH'(8)) begin
                        // fmt chunk too short to hold tag, channels and rate
                        if (err_reg == ST_OK) begin
                            err_next = ST_FORMAT;
                        end
                        phase_next = PH_STOP;
                    end else begin
                        left_next  = padded;
                        phase_next = (padded != '0) ? PH_BODY : PH_ID;
                    end
                end
            end
            PH_BODY: begin
                // Every body byte is payload of a data chunk except the pad byte,
                // which is the final byte of an odd-sized chunk.
                payload = (id_shift_reg == ID_DATA) && !(odd_reg && left_reg == BL_W'(1));
                if (id_shift_reg == ID_FMT && body_idx_reg < 4'd8) begin
                    fmt_shift_next = fmt_word;
                    if (body_idx_reg == 4'd7) begin
                        // Checked in the order format, rate, channels.
                        if (fmt_tag != exp_format_reg) begin
                            err_next   = ST_FORMAT;
                            phase_next = PH_STOP;
                        end else if (fmt_rate != exp_rate_reg) begin
                            err_next   = ST_RATE;
                            phase_next = PH_STOP;
                        end else if (fmt_chans != exp_chans_reg) begin
                            err_next   = ST_CHANS;
                            phase_next = PH_STOP;
                        end
                    end
                end
                if (body_idx_reg < 4'd8) begin
                    body_idx_next = body_idx_reg + 4'd1;
                end
                if (phase_next == PH_BODY) begin
                    left_next = left_reg - BL_W'(1);
                    if (left_next == '0) begin
                        phase_next = PH_ID;
                    end
                end
            end
            PH_TRAIL, PH_STOP: begin
                // Bytes pass through unmarked until the end of the file.
            end
            default: begin
                phase_next = PH_STOP;
            end
        endcase

        if (err_next != ST_OK) begin
            payload = 1'b0;
        end

        // "No data" is only judged on the last byte, and never over an id error.
        status = err_next;
        if (s_tlast && err_next == ST_OK && !seen_next) begin
            status = ST_NO_DATA;
        end

        if (offset_reg != 32'hFFFF_FFFF) begin
            offset_next = offset_reg + 32'd1;
        end

        // The last byte of a file leaves the parser ready for a new file.
        if (s_tlast) begin
            phase_next     = PH_HEADER;
            offset_next    = '0;
            riff_len_next  = '0;
            id_shift_next  = '0;
            len_shift_next = '0;
            odd_next       = 1'b0;
            left_next      = '0;
            body_idx_next  = '0;
            fmt_shift_next = '0;
            err_next       = ST_OK;
            seen_next      = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HEADER;
            offset_reg    <= '0;
            riff_len_reg  <= '0;
            id_shift_reg  <= '0;
            len_shift_reg <= '0;
            odd_reg       <= 1'b0;
            left_reg      <= '0;
            body_idx_reg  <= '0;
            fmt_shift_reg <= '0;
            err_reg       <= ST_OK;
            seen_reg      <= 1'b0;
        end else if (accept) begin
            phase_reg     <= phase_next;
            offset_reg    <= offset_next;
            riff_len_reg  <= riff_len_next;
            id_shift_reg  <= id_shift_next;
            len_shift_reg <= len_shift_next;
            odd_reg       <= odd_next;
            left_reg      <= left_next;
            body_idx_reg  <= body_idx_next;
            fmt_shift_reg <= fmt_shift_next;
            err_reg       <= err_next;
            seen_reg      <= seen_next;
        end
    end

    // ------------------------------------------------------------------
    // Output stage: a result register backed by a skid register. The input
    // side keeps taking bytes while a result waits, and stalls only once
    // the skid register is also full.
    // ------------------------------------------------------------------
    result_t new_res;
    result_t out_reg;
    result_t skid_reg;
    logic    out_valid_reg;
    logic    skid_valid_reg;
    logic    pop;

    assign new_res  = '{status: status, done: s_tlast, payload: payload, data: s_tdata};
    assign s_tready = !skid_valid_reg;
    assign pop      = out_valid_reg && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || pop) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= accept;
            end
        end else if (accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || pop) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (accept) begin
                out_reg <= new_res;
            end
        end else if (accept) begin
            skid_reg <= new_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_reg.status, out_reg.data};
    assign m_tuser  = out_reg.payload;
    assign m_tlast  = out_reg.done;

endmodule

>>> sv/rwcp_checker.sv
// Port-level checker for the RIFF/WAVE chunk parser, bound to the top level.
`timescale 1ns / 1ps

module rwcp_checker
    import rwcp_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // A waiting result is neither withdrawn nor changed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable({m_tdata, m_tuser, m_tlast}))
        else $error("result changed or dropped while stalled");

    // A payload byte never carries an error status.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[10:8] == ST_OK)
        else $error("payload marked with a non-zero status");

    // The input side only stalls while a result is waiting at the output.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with an empty output");

    // Reset empties the output stage.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

endmodule

bind riff_wave_chunk_parser rwcp_checker u_rwcp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

>>> verif/wave_mark_checker.sv
// Checker for the RIFF/WAVE chunk parser: predicts every marked byte and compares the result stream.
`timescale 1ns / 1ps

module wave_mark_checker
    import rwcp_pkg::*;
#(
    parameter int SIZE_WIDTH = SIZE_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [7:0]            s_tdata,
    input  logic                  s_tlast,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [15:0]           m_tdata,
    input  logic                  m_tuser,
    input  logic                  m_tlast,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output int                    fail_count,
    output int                    marks_waiting
);

    localparam logic [63:0] SIZE_MASK = (64'd1 << SIZE_WIDTH) - 64'd1;

    // Copy of the configuration registers.
    logic [15:0] want_format;
    logic [31:0] want_rate;
    logic [15:0] want_chans;

    // Copy of the parse state.
    logic [31:0] byte_pos;
    logic [31:0] riff_size;
    phase_t      phase;
    logic [31:0] id_word;
    logic [31:0] chunk_size;
    logic [32:0] remaining;
    logic [63:0] fmt_word;
    logic [2:0]  err_code;
    logic        seen_data;

    result_t predicted_marks[$];
    int      reported;

    task automatic clear_walk();
        byte_pos   = '0;
        riff_size  = '0;
        phase      = PH_HEADER;
        id_word    = '0;
        chunk_size = '0;
        remaining  = '0;
        fmt_word   = '0;
        err_code   = ST_OK;
        seen_data  = 1'b0;
    endtask

    // The first error found is kept; any error stops the walk.
    task automatic raise_fault(input logic [2:0] code);
        if (err_code == ST_OK) begin
            err_code = code;
        end
        phase = PH_STOP;
    endtask

    task automatic advance_parser(input logic [7:0] b, input logic is_last, output result_t r);
        logic        mark;
        logic [32:0] padded;
        logic [32:0] idx;
        logic [2:0]  st;
        mark = 1'b0;
        case (phase)
            PH_HEADER: begin
                id_word = {b, id_word[31:8]};
                if (byte_pos == OFS_RIFF_END && id_word != ID_RIFF) begin
                    raise_fault(ST_BAD_RIFF);
                end else if (byte_pos == OFS_SIZE_END) begin
                    riff_size = id_word & SIZE_MASK[31:0];
                end else if (byte_pos == OFS_WAVE_END) begin
                    if (id_word != ID_WAVE) begin
                        raise_fault(ST_BAD_WAVE);
                    end else begin
                        phase     = PH_ID;
                        remaining = '0;
                    end
                end
            end
            PH_ID: begin
                // A new chunk may only begin inside the region given by the RIFF size.
                if (remaining == 0 && {32'd0, byte_pos} >= 64'd8 + {32'd0, riff_size}) begin
                    phase = PH_TRAIL;
                end else begin
                    id_word   = {b, id_word[31:8]};
                    remaining = remaining + 1;
                    if (remaining >= 4) begin
                        phase     = PH_SIZE;
                        remaining = '0;
                    end
                end
            end
            PH_SIZE: begin
                chunk_size = {b, chunk_size[31:8]};
                remaining  = remaining + 1;
                if (remaining >= 4) begin
                    chunk_size = chunk_size & SIZE_MASK[31:0];
                    padded     = {1'b0, chunk_size} + chunk_size[0];
                    fmt_word   = '0;
                    if (id_word == ID_DATA) begin
                        seen_data = 1'b1;
                    end
                    if (id_word == ID_FMT && chunk_size < 8) begin
                        raise_fault(ST_FORMAT);
                    end else begin
                        remaining = padded;
                        phase     = (padded != 0) ? PH_BODY : PH_ID;
                    end
                end
            end
            PH_BODY: begin
                padded = {1'b0, chunk_size} + chunk_size[0];
                idx    = padded - remaining;
                if (id_word == ID_DATA && idx < {1'b0, chunk_size}) begin
                    mark = 1'b1;
                end
                if (id_word == ID_FMT && idx < 33'd8) begin
                    fmt_word = {b, fmt_word[63:8]};
                    if (idx == 33'd7) begin
                        if (fmt_word[15:0] != want_format) begin
                            raise_fault(ST_FORMAT);
                        end else if (fmt_word[63:32] != want_rate) begin
                            raise_fault(ST_RATE);
                        end else if (fmt_word[31:16] != want_chans) begin
                            raise_fault(ST_CHANS);
                        end
                    end
                end
                if (phase == PH_BODY) begin
                    remaining = remaining - 1;
                    if (remaining == 0) begin
                        phase = PH_ID;
                    end
                end
            end
            default: begin
            end
        endcase

        if (err_code != ST_OK) begin
            mark = 1'b0;
        end
        st = err_code;
        if (is_last && st == ST_OK && !seen_data) begin
            st = ST_NO_DATA;
        end
        r.data    = b;
        r.payload = mark;
        r.done    = is_last;
        r.status  = st;

        if (byte_pos != '1) begin
            byte_pos = byte_pos + 1;
        end
        if (is_last) begin
            clear_walk();
        end
    endtask

    always @(posedge aclk) begin
        result_t seen;
        result_t want;
        logic    orphan;
        logic    fault;
        if (!aresetn) begin
            want_format = FORMAT_RST;
            want_rate   = RATE_RST;
            want_chans  = CHANS_RST;
            clear_walk();
            predicted_marks.delete();
            reported = 0;
            fail_count    <= 0;
            marks_waiting <= 0;
        end else begin
            // Results are taken before the new byte is predicted: a byte's result
            // cannot leave at the edge that accepts the byte.
            if (m_tvalid && m_tready) begin
                seen.data    = m_tdata[7:0];
                seen.status  = m_tdata[10:8];
                seen.payload = m_tuser;
                seen.done    = m_tlast;
                orphan = (predicted_marks.size() == 0);
                if (orphan) begin
                    want  = '0;
                    fault = 1'b1;
                end else begin
                    want  = predicted_marks.pop_front();
                    fault = (seen.data != want.data) || (seen.payload != want.payload) ||
                            (seen.done != want.done) || (seen.status != want.status);
                end
                if (fault) begin
                    fail_count <= fail_count + 1;
                    if (reported < 10) begin
                        reported++;
                        if (orphan) begin
                            $display("%0t: result with none expected: data %02h payload %0d done %0d status %0d",
                                     $realtime, seen.data, seen.payload, seen.done, seen.status);
                        end else begin
                            $display("%0t: mismatch: expected data %02h payload %0d done %0d status %0d, got data %02h payload %0d done %0d status %0d",
                                     $realtime, want.data, want.payload, want.done, want.status,
                                     seen.data, seen.payload, seen.done, seen.status);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                advance_parser(s_tdata, s_tlast, want);
                predicted_marks.push_back(want);
            end
            if (psel && penable && pwrite && pready) begin
                case (paddr)
                    ADDR_FORMAT: want_format = pwdata[15:0];
                    ADDR_RATE:   want_rate   = pwdata;
                    ADDR_CHANS:  want_chans  = pwdata[15:0];
                    default: begin
                    end
                endcase
            end
            marks_waiting <= predicted_marks.size();
        end
    end

endmodule

>>> verif/tb_riff_wave_chunk_parser.sv
// Testbench top for the RIFF/WAVE chunk parser: stimulus, flow control and the verdict.
`timescale 1ns / 1ps

module tb_riff_wave_chunk_parser;
    import rwcp_pkg::*;

    // Generous bound on the whole run; a correct run needs only a small part of it.
    localparam int CYCLE_LIMIT = 200_000;
    // Least number of random bytes to send in each phase, five phases in all.
    localparam int PHASE_BYTES = 50;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata  = '0;   // [7:0] file_byte
    logic                  s_tlast  = 1'b0; // last_byte
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [15:0]           m_tdata;         // [7:0] byte_out, [10:8] status, [15:11] zero
    logic                  m_tuser;         // is_payload
    logic                  m_tlast;         // done_res
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr    = '0;
    logic [31:0]           pwdata   = '0;
    logic [31:0]           prdata;
    logic                  pready;

    int fail_count;
    int marks_waiting;
    int cycle_count;

    // Idling odds of the current phase, in percent.
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;

    // Register values as last written; the file generator uses them to build fmt
    // chunks that pass or fail on purpose.
    logic [15:0] cfg_format = FORMAT_RST;
    logic [31:0] cfg_rate   = RATE_RST;
    logic [15:0] cfg_chans  = CHANS_RST;

    // The file being built, in file order.
    logic [7:0] wave_file[$];

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    riff_wave_chunk_parser i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    wave_mark_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .fail_count    (fail_count),
        .marks_waiting (marks_waiting)
    );

    // The receiver stalls at random with the odds of the current phase.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // Appends the low n bytes of a word, least significant first, as RIFF stores them.
    task automatic append_le(input logic [31:0] word, input int n);
        for (int i = 0; i < n; i++) begin
            wave_file.push_back(word[8*i +: 8]);
        end
    endtask

    // One byte transfer. The sender may idle before it; tvalid stays high
    // between back-to-back bytes.
    task automatic send_byte(input logic [7:0] value, input logic is_last);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= is_last;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic stream_wave_file();
        for (int i = 0; i < wave_file.size(); i++) begin
            send_byte(wave_file[i], i == wave_file.size() - 1);
        end
    endtask

    // Holds the sender back until every predicted result has been taken. The
    // count from the checker is registered, so the clock is always waited on.
    task automatic wait_until_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (marks_waiting != 0);
    endtask

    // One APB write. psel stays high on return so that writes can follow back to
    // back; the caller closes the sequence.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
    endtask

    task automatic load_expectations(input logic [15:0] fmt_tag, input logic [31:0] rate,
                                     input logic [15:0] chans);
        write_reg(ADDR_FORMAT, {16'd0, fmt_tag});
        write_reg(ADDR_RATE, rate);
        write_reg(ADDR_CHANS, {16'd0, chans});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_format = fmt_tag;
        cfg_rate   = rate;
        cfg_chans  = chans;
    endtask

    // Builds one random file into wave_file. Most files are well formed with
    // random chunk lists, so that the parser reaches the chunk walk and the fmt
    // checks; the rest have a damaged id, are cut short, or are plain noise.
    task automatic compose_wave_file();
        int          kind;
        int          n_chunks;
        int          len;
        int          pick;
        int          body_len;
        int          cut;
        logic        stop_chunks;
        logic [31:0] riff_id;
        logic [31:0] wave_id;
        logic [31:0] riff_size;
        logic [31:0] chunk_id;
        logic [15:0] fmt_tag;
        logic [15:0] fmt_chans;
        logic [31:0] fmt_rate;
        logic [63:0] fmt_fields;
        wave_file.delete();
        kind = $urandom_range(0, 99);

        // Noise: random bytes, mostly failing on the RIFF id or ending inside the header.
        if (kind >= 85) begin
            len = $urandom_range(1, 24);
            repeat (len) wave_file.push_back($urandom_range(0, 255));
            return;
        end

        riff_id = ID_RIFF;
        wave_id = ID_WAVE;
        if (kind >= 70 && kind < 78) begin
            if ($urandom_range(0, 1) == 0) begin
                riff_id[$urandom_range(0, 31)] ^= 1'b1;
            end else begin
                wave_id[$urandom_range(0, 31)] ^= 1'b1;
            end
        end
        append_le(riff_id, 4);
        append_le(32'd0, 4);   // the RIFF size is filled in once the body is known
        append_le(wave_id, 4);

        n_chunks    = $urandom_range(1, 4);
        stop_chunks = 1'b0;
        for (int k = 0; k < n_chunks && !stop_chunks; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                // fmt chunk: now and then too short, and each field may be made wrong,
                // one or several at once, so that the order of the checks shows.
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7)
                                                  : $urandom_range(8, 14);
                fmt_tag   = ($urandom_range(0, 5) == 0)
                          ? cfg_format ^ 16'($urandom_range(1, 65535)) : cfg_format;
                fmt_chans = ($urandom_range(0, 5) == 0)
                          ? cfg_chans ^ 16'($urandom_range(1, 65535)) : cfg_chans;
                fmt_rate  = ($urandom_range(0, 5) == 0) ? cfg_rate ^ ($urandom() | 32'd1)
                                                        : cfg_rate;
                fmt_fields = {fmt_rate, fmt_chans, fmt_tag};
                append_le(ID_FMT, 4);
                append_le(len, 4);
                for (int j = 0; j < len; j++) begin
                    wave_file.push_back((j < 8) ? fmt_fields[8*j +: 8]
                                                : 8'($urandom_range(0, 255)));
                end
                if (len % 2 == 1) begin
                    wave_file.push_back($urandom_range(0, 255));
                end
            end else begin
                // data chunk, or another chunk whose id may miss "data" by one bit.
                if (pick < 75) begin
                    chunk_id = ID_DATA;
                end else if (pick < 88) begin
                    chunk_id = ID_DATA ^ (32'd1 << $urandom_range(0, 31));
                end else begin
                    chunk_id = $urandom();
                end
                append_le(chunk_id, 4);
                if ($urandom_range(0, 19) == 0) begin
                    // A huge size: the file ends long before the chunk would.
                    append_le($urandom(), 4);
                    repeat ($urandom_range(0, 6)) wave_file.push_back($urandom_range(0, 255));
                    stop_chunks = 1'b1;
                end else begin
                    len = $urandom_range(0, 16);
                    append_le(len, 4);
                    repeat (len + len % 2) wave_file.push_back($urandom_range(0, 255));
                end
            end
        end

        // The RIFF size usually covers the body exactly; otherwise the region ends
        // early, runs past the end of the file, or is any value at all.
        body_len = wave_file.size() - 8;
        pick     = $urandom_range(0, 99);
        if (pick < 70) begin
            riff_size = body_len;
        end else if (pick < 80) begin
            riff_size = $urandom_range(0, body_len - 1);
        end else if (pick < 90) begin
            riff_size = body_len + $urandom_range(1, 12);
        end else begin
            riff_size = $urandom();
        end
        for (int i = 0; i < 4; i++) begin
            wave_file[4 + i] = riff_size[8*i +: 8];
        end

        // Trailing bytes beyond the chunk region.
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 6)) wave_file.push_back($urandom_range(0, 255));
        end

        // Cut short, anywhere from inside the header to the last byte.
        if (kind >= 78) begin
            cut = $urandom_range(1, wave_file.size() - 1);
            while (wave_file.size() > cut) begin
                wave_file.delete(wave_file.size() - 1);
            end
        end
    endtask

    initial begin
        int phase_bytes;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed files under the reset configuration and without idling.
        // A one-byte file: it ends inside the header with no id error, so no data.
        wave_file.delete();
        wave_file.push_back(8'hFF);
        stream_wave_file();
        // "RIFX" and a zero byte: a bad RIFF id, kept to the end of the file.
        wave_file.delete();
        append_le({8'h58, ID_RIFF[23:0]}, 4);
        wave_file.push_back(8'h00);
        stream_wave_file();
        // A good RIFF id with an all-ones size, then "WAVf": a bad WAVE id.
        wave_file.delete();
        append_le(ID_RIFF, 4);
        append_le(32'hFFFF_FFFF, 4);
        append_le({8'h66, ID_WAVE[23:0]}, 4);
        stream_wave_file();

        // Random files in five phases. Between phases the sender waits until every
        // result has arrived, the registers are rewritten, and the idling changes.
        for (int ph = 0; ph < 5; ph++) begin
            wait_until_drained();
            case (ph)
                0: begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 0;
                end
                1: begin
                    load_expectations(16'd1, 32'd48000, 16'd2);
                    sender_idle_pct = 77;
                    recv_stall_pct  = 0;
                end
                2: begin
                    load_expectations(16'd0, 32'd0, 16'd0);
                    sender_idle_pct = 0;
                    recv_stall_pct  = 77;
                end
                3: begin
                    load_expectations(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
                    sender_idle_pct = 17;
                    recv_stall_pct  = 17;
                end
                default: begin
                    load_expectations($urandom_range(0, 65535), $urandom(),
                                      $urandom_range(0, 65535));
                    sender_idle_pct = 0;
                    recv_stall_pct  = 0;
                end
            endcase

            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES) begin
                compose_wave_file();
                phase_bytes += wave_file.size();
                stream_wave_file();
                // Now and then the sender also pauses until the pipeline is empty.
                if ($urandom_range(0, 4) == 0) begin
                    wait_until_drained();
                end
            end
        end

        // Let the last results out, then give any stray result time to show.
        wait_until_drained();
        repeat (4) @(posedge aclk);
        if (fail_count == 0 && marks_waiting == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
